### rtl/core/acf_pkg.sv
// Shared types and constants of the ASCII stream chunk framer.
// Used by acf_front, acf_queue, acf_back and ascii_stream_chunk_framer.
// Depends on nothing.
package acf_pkg;

    // Input opcodes carried on s_tuser.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_STREAM_ID     = 1'b0;
    localparam logic CFG_MAX_FRAME_LEN = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [9:0] STREAM_ID_RESET     = 10'd1;
    localparam logic [7:0] MAX_FRAME_LEN_RESET = 8'd64;

    // Header lengths and the modulus of printed numbers.
    localparam logic [7:0] HDR_START_LEN = 8'd5;
    localparam logic [7:0] HDR_CONT_LEN  = 8'd8;
    localparam logic [9:0] NUM_MOD       = 10'd1000;

    // ASCII characters of the headers.
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [3:0] digit_t;

    // Three decimal digits, hundreds first.
    typedef struct packed {
        digit_t d2;
        digit_t d1;
        digit_t d0;
    } num3_t;

    // Kind of work the back end carries out for one accepted item.
    typedef enum logic [4:0] {
        K_ERR   = 5'b00001,
        K_START = 5'b00010,
        K_CONT  = 5'b00100,
        K_DATA  = 5'b01000,
        K_END   = 5'b10000
    } kind_t;

    // One queued command.
    typedef struct packed {
        kind_t      kind;
        num3_t      seq;
        logic [7:0] data;
        logic       fend;
    } cmd_t;

    // Decimal increment of a three-digit counter, 999 wraps to 000.
    function automatic num3_t num3_inc(input num3_t v);
        num3_t r;
        r = v;
        if (v.d0 == 4'd9) begin
            r.d0 = 4'd0;
            if (v.d1 == 4'd9) begin
                r.d1 = 4'd0;
                r.d2 = (v.d2 == 4'd9) ? 4'd0 : v.d2 + 4'd1;
            end else begin
                r.d1 = v.d1 + 4'd1;
            end
        end else begin
            r.d0 = v.d0 + 4'd1;
        end
        return r;
    endfunction

    // ASCII code of one decimal digit.
    function automatic logic [7:0] digit_char(input digit_t d);
        return CHAR_ZERO | {4'd0, d};
    endfunction

endpackage

### rtl/core/ascii_stream_chunk_framer.sv
// Top level of the ASCII stream chunk framer.
// Depends on acf_pkg, acf_front, acf_queue and acf_back.
//
// Usage:
// The slave channel takes one item per transfer: s_tuser is the opcode
// (start, data byte, end), s_tdata the payload byte and s_tlast the end of
// a write. The master channel gives one link byte per transfer on m_tdata,
// with m_tlast on the final byte of a frame and m_tuser carrying the
// last-result flag and the error status.
// The front end takes an item whenever the queue is not full and queues one
// command; the back end emits one byte a cycle unless the output stalls,
// so an item's first byte passes through the queue and the output register.
// Data bytes in an open frame pass at one item per cycle when not stalled;
// a start gives 5 bytes, a data byte that opens a frame 9 and an end 8, which
// the 4-entry queue absorbs until it fills. Output byte rate sets throughput.
// When the receiver stalls the output register holds its byte, the queue
// fills and s_tready drops; nothing is lost. Reset clears the sequence to 0,
// closes any frame, sets the stream id to 1 and the frame limit to 64, and
// empties the queue and the output register. The user must write the
// configuration port only while the block is idle; the block does not check.
module ascii_stream_chunk_framer #(
    parameter int FRAME_BUF_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [9:0]  cfg_wdata,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        s_tlast,   // last_of_write
    // Framed link bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] run_last, [1] status
    output logic        m_tlast    // frame_end
);

    logic            push_valid;
    acf_pkg::cmd_t   push_cmd;
    logic            queue_full;
    logic            queue_empty;
    logic            pop;
    acf_pkg::cmd_t   head_cmd;
    acf_pkg::num3_t  id_digits;
    logic            run_last;
    logic            status;

    assign m_tuser = {status, run_last};

    // Item classification and frame state.
    acf_front #(
        .FRAME_BUF_BYTES(FRAME_BUF_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tuser),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .id_digits  (id_digits)
    );

    // Command queue between the two halves.
    acf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    // Byte expansion and output register.
    acf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .head_empty    (queue_empty),
        .pop           (pop),
        .id_digits     (id_digits),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_frame_end (m_tlast),
        .out_run_last  (run_last),
        .out_status    (status)
    );

endmodule

### rtl/core/acf_front.sv
// Front end of the framer: accepts input transfers, holds the frame state
// and the configuration, and turns each item into one queued command.
// Depends on acf_pkg.
module acf_front #(
    parameter int FRAME_BUF_BYTES = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [9:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_opcode,
    input  logic [7:0]       in_data,
    input  logic             in_last,
    input  logic             queue_full,
    output logic             push_valid,
    output acf_pkg::cmd_t    push_cmd,
    output acf_pkg::num3_t   id_digits
);

    localparam logic [7:0] LIMIT_CAP = 8'(FRAME_BUF_BYTES - 1);

    logic [7:0]      max_len_reg;
    logic [9:0]      id_mod_reg;
    logic [3:0]      id_hund_reg;
    acf_pkg::num3_t  id_digits_reg;
    acf_pkg::num3_t  seq_reg, seq_next;
    logic            open_reg, open_next;
    logic [7:0]      count_reg, count_next;

    logic [7:0]      limit;
    logic [7:0]      room;
    logic [7:0]      count_new;
    logic            close_now;
    logic            accept;
    acf_pkg::num3_t  seq_inc;
    logic [9:0]      wr_mod;
    logic [6:0]      id_rem;
    logic [3:0]      id_tens;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign id_digits = id_digits_reg;

    // Effective frame limit and the payload room after a continuation header.
    assign limit = (max_len_reg < LIMIT_CAP) ? max_len_reg : LIMIT_CAP;
    assign room  = (limit > acf_pkg::HDR_CONT_LEN) ? limit - acf_pkg::HDR_CONT_LEN : 8'd0;
    assign seq_inc = acf_pkg::num3_inc(seq_reg);

    // Stream id to decimal: reduce mod 1000 and find hundreds at the write,
    // tens and ones in the cycle after.
    assign wr_mod  = (cfg_wdata >= acf_pkg::NUM_MOD) ? cfg_wdata - acf_pkg::NUM_MOD : cfg_wdata;
    assign id_rem  = 7'(id_mod_reg - 10'(id_hund_reg) * 10'd100);
    assign id_tens = 4'((15'(id_rem) * 15'd205) >> 11);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= acf_pkg::MAX_FRAME_LEN_RESET;
            id_mod_reg    <= acf_pkg::STREAM_ID_RESET;
            id_hund_reg   <= 4'd0;
            id_digits_reg <= '{d2: 4'd0, d1: 4'd0, d0: 4'd1};
        end else begin
            if (cfg_wr_en && cfg_addr == acf_pkg::CFG_STREAM_ID) begin
                id_mod_reg  <= wr_mod;
                id_hund_reg <= 4'((16'(wr_mod) * 16'd41) >> 12);
            end
            if (cfg_wr_en && cfg_addr == acf_pkg::CFG_MAX_FRAME_LEN) begin
                max_len_reg <= cfg_wdata[7:0];
            end
            id_digits_reg.d2 <= id_hund_reg;
            id_digits_reg.d1 <= id_tens;
            id_digits_reg.d0 <= 4'(id_rem - 7'(id_tens) * 7'd10);
        end
    end

    // Classify the item, build its command and the next frame state.
    always_comb begin
        seq_next       = seq_reg;
        open_next      = open_reg;
        count_next     = count_reg;
        push_valid     = 1'b0;
        push_cmd.kind  = acf_pkg::K_ERR;
        push_cmd.seq   = seq_reg;
        push_cmd.data  = in_data;
        push_cmd.fend  = 1'b0;
        count_new      = open_reg ? count_reg + 8'd1 : 8'd1;
        close_now      = (count_new >= room) || in_last;
        case (in_opcode)
            acf_pkg::OP_START: begin
                seq_next      = '0;
                open_next     = 1'b0;
                count_next    = 8'd0;
                push_valid    = accept;
                push_cmd.kind = (limit < acf_pkg::HDR_START_LEN) ? acf_pkg::K_ERR
                                                                 : acf_pkg::K_START;
            end
            acf_pkg::OP_DATA: begin
                push_valid = accept;
                if (!open_reg && limit <= acf_pkg::HDR_CONT_LEN) begin
                    push_cmd.kind = acf_pkg::K_ERR;
                end else begin
                    push_cmd.kind = open_reg ? acf_pkg::K_DATA : acf_pkg::K_CONT;
                    push_cmd.fend = close_now;
                    if (close_now) begin
                        open_next  = 1'b0;
                        count_next = 8'd0;
                        seq_next   = seq_inc;
                    end else begin
                        open_next  = 1'b1;
                        count_next = count_new;
                    end
                end
            end
            acf_pkg::OP_END: begin
                push_valid = accept;
                if (open_reg) begin
                    seq_next = seq_inc;
                end
                open_next     = 1'b0;
                count_next    = 8'd0;
                push_cmd.seq  = open_reg ? seq_inc : seq_reg;
                push_cmd.kind = (limit < acf_pkg::HDR_CONT_LEN) ? acf_pkg::K_ERR
                                                                : acf_pkg::K_END;
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase
    end

    // Frame state advances only on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= '0;
            open_reg  <= 1'b0;
            count_reg <= 8'd0;
        end else if (accept) begin
            seq_reg   <= seq_next;
            open_reg  <= open_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/acf_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on acf_pkg.
module acf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  acf_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output acf_pkg::cmd_t  head_cmd,
    output logic           empty
);

    localparam int PW = acf_pkg::QUEUE_PTR_W;

    acf_pkg::cmd_t       slot_reg [acf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == (PW + 1)'(acf_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Storage has no reset; only the pointers and the fill count do.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
        end
    end

endmodule

### rtl/core/acf_back.sv
// Back end of the framer: expands each queued command into link bytes,
// one per cycle unless stalled, into a registered output stage.
// Depends on acf_pkg.
module acf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  acf_pkg::cmd_t   head_cmd,
    input  logic            head_empty,
    output logic            pop,
    input  acf_pkg::num3_t  id_digits,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_frame_end,
    output logic            out_run_last,
    output logic            out_status
);

    logic [3:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        fend_reg;
    logic        rlast_reg;
    logic        status_reg;

    logic        load;
    logic [7:0]  sel_byte;
    logic        sel_fend;
    logic        sel_final;
    logic        sel_status;
    logic [7:0]  hdr_char;

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_frame_end = fend_reg;
    assign out_run_last  = rlast_reg;
    assign out_status    = status_reg;

    assign load = !head_empty && (!valid_reg || out_ready);
    assign pop  = load && sel_final;

    // Header byte at the current position: marker, letter, id, sequence.
    always_comb begin
        case (idx_reg)
            4'd0: hdr_char = acf_pkg::CHAR_TILDE;
            4'd1: hdr_char = (head_cmd.kind == acf_pkg::K_START) ? acf_pkg::CHAR_S :
                             (head_cmd.kind == acf_pkg::K_END)   ? acf_pkg::CHAR_E :
                                                                   acf_pkg::CHAR_C;
            4'd2: hdr_char = acf_pkg::digit_char(id_digits.d2);
            4'd3: hdr_char = acf_pkg::digit_char(id_digits.d1);
            4'd4: hdr_char = acf_pkg::digit_char(id_digits.d0);
            4'd5: hdr_char = acf_pkg::digit_char(head_cmd.seq.d2);
            4'd6: hdr_char = acf_pkg::digit_char(head_cmd.seq.d1);
            4'd7: hdr_char = acf_pkg::digit_char(head_cmd.seq.d0);
            default: hdr_char = head_cmd.data;
        endcase
    end

    // Per-kind choice of byte, frame end and the last byte of the item.
    always_comb begin
        sel_byte   = hdr_char;
        sel_fend   = 1'b0;
        sel_final  = 1'b0;
        sel_status = 1'b0;
        case (head_cmd.kind)
            acf_pkg::K_ERR: begin
                sel_byte   = 8'd0;
                sel_final  = 1'b1;
                sel_status = 1'b1;
            end
            acf_pkg::K_START: begin
                sel_final = (idx_reg == 4'd4);
                sel_fend  = sel_final;
            end
            acf_pkg::K_CONT: begin
                sel_final = (idx_reg == 4'd8);
                sel_fend  = sel_final && head_cmd.fend;
            end
            acf_pkg::K_DATA: begin
                sel_byte  = head_cmd.data;
                sel_final = 1'b1;
                sel_fend  = head_cmd.fend;
            end
            acf_pkg::K_END: begin
                sel_final = (idx_reg == 4'd7);
                sel_fend  = sel_final;
            end
            default: begin
                sel_final = 1'b1;
            end
        endcase
    end

    // Output stage payload loads when a command waits and it is free or taken.
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= sel_byte;
            fend_reg   <= sel_fend;
            rlast_reg  <= sel_final;
            status_reg <= sel_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= sel_final ? 4'd0 : idx_reg + 4'd1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
